// File: rtl/ba_pkg.sv
package ba_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_POP_RD,
        ST_POP_WAIT,
        ST_SPLIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MERGE,
        ST_PUSH,
        ST_DONE
    } ba_state_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic load;
        logic find_step;
        logic pop_rd;
        logic pop_take;
        logic split_step;
        logic scan_start;
        logic scan_rd;
        logic scan_chk;
        logic merge_step;
        logic push;
        logic fail;
        logic finish;
    } ba_cmd_t;

    typedef struct packed {
        logic func;
        logic req_bad;
        logic free_bad;
        logic find_hit;
        logic find_end;
        logic split_end;
        logic at_top;
        logic scan_end;
        logic scan_found;
    } ba_sts_t;

endpackage

// File: rtl/ba_ctrl.sv
module ba_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            out_busy,
    input  ba_pkg::ba_sts_t sts,
    output ba_pkg::ba_cmd_t cmd,
    output logic            idle
);

    ba_pkg::ba_state_t state_reg;
    ba_pkg::ba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            ba_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ba_pkg::ST_FIND;
                end
            end
            ba_pkg::ST_FIND:
            begin
                if (sts.func == ba_pkg::FUNC_ALLOC)
                begin
                    if (sts.req_bad)
                    begin
                        cmd.fail = 1'b1;
                        state_next = ba_pkg::ST_DONE;
                    end
                    else if (sts.find_hit)
                    begin
                        state_next = ba_pkg::ST_POP_RD;
                    end
                    else if (sts.find_end)
                    begin
                        cmd.fail = 1'b1;
                        state_next = ba_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.find_step = 1'b1;
                    end
                end
                else if (sts.free_bad)
                begin
                    cmd.fail = 1'b1;
                    state_next = ba_pkg::ST_DONE;
                end
                else if (sts.at_top)
                begin
                    state_next = ba_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next = ba_pkg::ST_SCAN_RD;
                end
            end
            ba_pkg::ST_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = ba_pkg::ST_POP_WAIT;
            end
            ba_pkg::ST_POP_WAIT:
            begin
                cmd.pop_take = 1'b1;
                state_next = ba_pkg::ST_SPLIT;
            end
            ba_pkg::ST_SPLIT:
            begin
                if (sts.split_end)
                begin
                    state_next = ba_pkg::ST_DONE;
                end
                else
                begin
                    cmd.split_step = 1'b1;
                end
            end
            ba_pkg::ST_SCAN_RD:
            begin
                if (sts.scan_end)
                begin
                    state_next = sts.scan_found ? ba_pkg::ST_MERGE : ba_pkg::ST_PUSH;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next = ba_pkg::ST_SCAN_CHK;
                end
            end
            ba_pkg::ST_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next = ba_pkg::ST_SCAN_RD;
            end
            ba_pkg::ST_MERGE:
            begin
                cmd.merge_step = 1'b1;
                state_next = ba_pkg::ST_FIND;
            end
            ba_pkg::ST_PUSH:
            begin
                cmd.push = 1'b1;
                state_next = ba_pkg::ST_DONE;
            end
            ba_pkg::ST_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ba_pkg::ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ba_pkg::ST_SCAN_CHK) |=> (state_reg == ba_pkg::ST_SCAN_RD))
        else $error("scan check not followed by read");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !out_busy)
        else $error("result finished into a busy output");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ba_pkg::ST_POP_RD) |=> (state_reg == ba_pkg::ST_POP_WAIT))
        else $error("pop sequence broken");

endmodule

// File: rtl/ba_datapath.sv
module ba_datapath #(
    parameter int HEAP_ORDER = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ba_pkg::ba_cmd_t       cmd,
    output ba_pkg::ba_sts_t       sts,
    input  logic                  func,
    input  logic [HEAP_ORDER:0]   req_size,
    input  logic [HEAP_ORDER-1:0] free_start,
    input  logic [HEAP_ORDER:0]   free_end,
    input  logic [HEAP_ORDER:0]   max_request,
    output logic                  res_ok,
    output logic [HEAP_ORDER-1:0] res_start,
    output logic [HEAP_ORDER:0]   res_end
);

    localparam int NORD = HEAP_ORDER + 1;
    localparam int OW = $clog2(NORD + 1);
    localparam int AW = HEAP_ORDER + 1;
    localparam int DEPTH = 2 << HEAP_ORDER;
    localparam int CW = HEAP_ORDER + 1;
    localparam logic [AW-1:0] TOP_BASE = AW'(DEPTH - 2);

    logic [HEAP_ORDER-1:0] mem [DEPTH];
    logic [HEAP_ORDER-1:0] rd_data_reg;

    logic [CW-1:0] cnt_reg [NORD];
    logic [CW-1:0] cnt_next [NORD];

    logic                  func_reg;
    logic [OW-1:0]         k_reg, k_next;
    logic [OW-1:0]         j_reg, j_next;
    logic [HEAP_ORDER-1:0] pos_reg, pos_next;
    logic [CW-1:0]         r_reg, r_next;
    logic [CW-1:0]         w_reg, w_next;
    logic                  found_reg, found_next;
    logic                  ok_reg, ok_next;
    logic                  req_bad_reg;
    logic                  free_bad_reg;
    logic                  top_fresh_reg;

    logic [HEAP_ORDER:0]   req_m1;
    logic [OW-1:0]         req_ord;
    logic [HEAP_ORDER:0]   flen;
    logic [OW-1:0]         free_ord;
    logic [HEAP_ORDER-1:0] bud;
    logic [AW-1:0]         j_base, k_base;
    logic [CW-1:0]         cap_k;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [HEAP_ORDER-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    function automatic logic [AW-1:0] base_of(input logic [OW-1:0] k);
        logic [AW:0] full;
        full = (AW+1)'(DEPTH) - ((AW+1)'(2) << (HEAP_ORDER - int'(k)));
        return full[AW-1:0];
    endfunction

    always_comb
    begin
        req_m1 = req_size - 1'b1;
        req_ord = '0;
        for (int i = 0; i <= HEAP_ORDER; i++)
        begin
            if (req_m1[i])
            begin
                req_ord = OW'(i + 1);
            end
        end
        flen = free_end - {1'b0, free_start};
        free_ord = '0;
        for (int i = 0; i <= HEAP_ORDER; i++)
        begin
            if (flen[i])
            begin
                free_ord = OW'(i);
            end
        end
    end

    assign bud = pos_reg ^ HEAP_ORDER'(({{(HEAP_ORDER-1){1'b0}}, 1'b1}) << k_reg);
    assign j_base = base_of(j_reg);
    assign k_base = base_of(k_reg);
    assign cap_k = CW'(1) << (HEAP_ORDER - int'(k_reg));

    assign sts.func = func_reg;
    assign sts.req_bad = req_bad_reg;
    assign sts.free_bad = free_bad_reg;
    assign sts.find_hit = (int'(j_reg) <= HEAP_ORDER) && (cnt_reg[j_reg] != '0);
    assign sts.find_end = (int'(j_reg) >= HEAP_ORDER);
    assign sts.split_end = (j_reg == k_reg);
    assign sts.at_top = (int'(k_reg) >= HEAP_ORDER);
    assign sts.scan_end = (r_reg == cnt_reg[k_reg]);
    assign sts.scan_found = found_reg;

    always_comb
    begin
        k_next = k_reg;
        j_next = j_reg;
        pos_next = pos_reg;
        r_next = r_reg;
        w_next = w_reg;
        found_next = found_reg;
        ok_next = ok_reg;
        for (int i = 0; i < NORD; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en = 1'b0;
        rd_addr = '0;
        if (cmd.load)
        begin
            ok_next = 1'b0;
            if (func == ba_pkg::FUNC_ALLOC)
            begin
                k_next = (req_size == 1) ? '0 : req_ord;
                j_next = (req_size == 1) ? '0 : req_ord;
            end
            else
            begin
                k_next = free_ord;
                pos_next = free_start;
            end
        end
        if (cmd.find_step)
        begin
            j_next = j_reg + 1'b1;
        end
        if (cmd.pop_rd)
        begin
            cnt_next[j_reg] = cnt_reg[j_reg] - 1'b1;
            rd_en = 1'b1;
            rd_addr = j_base + AW'(cnt_reg[j_reg] - 1'b1);
        end
        if (cmd.pop_take)
        begin
            // top entry reads as block 0 until first written
            pos_next = (top_fresh_reg && int'(j_reg) == HEAP_ORDER) ? '0 : rd_data_reg;
        end
        if (cmd.split_step)
        begin
            j_next = j_reg - 1'b1;
            wr_addr = base_of(j_reg - 1'b1) + AW'(cnt_reg[j_reg - 1'b1]);
            wr_data = pos_reg + HEAP_ORDER'(
                ({{(HEAP_ORDER-1){1'b0}}, 1'b1}) << (j_reg - 1'b1));
            if (cnt_reg[j_reg - 1'b1] < (CW'(1) << (HEAP_ORDER - int'(j_reg) + 1)))
            begin
                wr_en = 1'b1;
                cnt_next[j_reg - 1'b1] = cnt_reg[j_reg - 1'b1] + 1'b1;
            end
        end
        if (cmd.scan_start)
        begin
            r_next = '0;
            w_next = '0;
            found_next = 1'b0;
        end
        if (cmd.scan_rd)
        begin
            rd_en = 1'b1;
            rd_addr = k_base + AW'(r_reg);
        end
        if (cmd.scan_chk)
        begin
            r_next = r_reg + 1'b1;
            if (rd_data_reg == bud)
            begin
                found_next = 1'b1;
            end
            else
            begin
                wr_en = 1'b1;
                wr_addr = k_base + AW'(w_reg);
                wr_data = rd_data_reg;
                w_next = w_reg + 1'b1;
            end
        end
        if (cmd.merge_step)
        begin
            cnt_next[k_reg] = w_reg;
            if (bud < pos_reg)
            begin
                pos_next = bud;
            end
            k_next = k_reg + 1'b1;
        end
        if (cmd.push)
        begin
            ok_next = 1'b1;
            if (cnt_reg[k_reg] < cap_k)
            begin
                wr_en = 1'b1;
                wr_addr = k_base + AW'(cnt_reg[k_reg]);
                wr_data = pos_reg;
                cnt_next[k_reg] = cnt_reg[k_reg] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            req_bad_reg <= (req_size == '0) || (req_size > max_request)
                || (int'(req_ord) > HEAP_ORDER && req_size != 1);
            free_bad_reg <= (free_end <= {1'b0, free_start});
        end
        k_reg <= k_next;
        j_reg <= j_next;
        pos_reg <= pos_next;
        r_reg <= r_next;
        w_reg <= w_next;
        found_reg <= found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
            top_fresh_reg <= 1'b1;
            for (int i = 0; i < NORD; i++)
            begin
                cnt_reg[i] <= (i == HEAP_ORDER) ? CW'(1) : '0;
            end
        end
        else
        begin
            ok_reg <= ok_next;
            if (wr_en && wr_addr == TOP_BASE)
            begin
                top_fresh_reg <= 1'b0;
            end
            for (int i = 0; i < NORD; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    logic alloc_done;
    assign alloc_done = (func_reg == ba_pkg::FUNC_ALLOC) && !req_bad_reg;
    assign res_ok = alloc_done ? !cmd.fail : ok_reg;
    assign res_start = alloc_done ? pos_reg : '0;
    assign res_end = alloc_done ? ({1'b0, pos_reg} + ((HEAP_ORDER+1)'(1) << k_reg)) : '0;

endmodule

// File: rtl/buddy_allocator_top.sv
// Buddy allocator over 2^HEAP_ORDER units with one LIFO free stack per order,
// one item at a time. After reset the top order holds block 0; the stack store
// is not cleared, only the fill counts and a flag standing for the top entry.
// An allocate climbs the orders to reach a free block, then splits it down to
// the requested order. A free scans the stack entries of each order visited
// for the buddy, merging up until none is found or the top order is reached,
// so a large order-0 stack makes a free slow. The next item is accepted the
// cycle after the result is registered, later while out_stall holds a result.
// A failed allocate returns ok 0 and zero bounds; a bad free returns ok 0.
module buddy_allocator_top #(
    parameter int HEAP_ORDER = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  func,
    input  logic [HEAP_ORDER:0]   req_size,
    input  logic [HEAP_ORDER-1:0] free_start,
    input  logic [HEAP_ORDER:0]   free_end,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [HEAP_ORDER-1:0] got_start,
    output logic [HEAP_ORDER:0]   got_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [HEAP_ORDER:0]   cfg_data
);

    ba_pkg::ba_cmd_t cmd;
    ba_pkg::ba_sts_t sts;
    logic idle;
    logic start;
    logic [HEAP_ORDER:0] max_request_reg;
    logic res_ok;
    logic [HEAP_ORDER-1:0] res_start;
    logic [HEAP_ORDER:0] res_end;
    logic out_valid_reg;
    logic ok_reg;
    logic [HEAP_ORDER-1:0] got_start_reg;
    logic [HEAP_ORDER:0] got_end_reg;

    assign cfg_ready = 1'b1;
    assign in_stall = !idle;
    assign start = in_valid && idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_request_reg <= (HEAP_ORDER+1)'(1) << HEAP_ORDER;
        end
        else if (cfg_valid)
        begin
            max_request_reg <= cfg_data;
        end
    end

    ba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_busy (out_valid_reg && out_stall),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    ba_datapath #(.HEAP_ORDER(HEAP_ORDER)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .req_size    (req_size),
        .free_start  (free_start),
        .free_end    (free_end),
        .max_request (max_request_reg),
        .res_ok      (res_ok),
        .res_start   (res_start),
        .res_end     (res_end)
    );

    logic fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fail_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                fail_reg <= 1'b0;
            end
            else if (cmd.fail)
            begin
                fail_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg <= res_ok && !fail_reg;
            got_start_reg <= fail_reg ? '0 : res_start;
            got_end_reg <= fail_reg ? '0 : res_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign ok = ok_reg;
    assign got_start = got_start_reg;
    assign got_end = got_end_reg;

endmodule

// File: dv/buddy_allocator_top_tb.sv
`timescale 1ns / 1ps

module buddy_allocator_top_tb;

    localparam int HO      = 12;
    localparam int NORD    = HO + 1;
    localparam int UNITS   = 1 << HO;
    localparam int LIMIT   = 20000000;
    localparam int N_RAND  = 100;

    typedef struct {
        logic          f;
        logic [HO:0]   req;
        logic [HO-1:0] fs;
        logic [HO:0]   fe;
        bit            typed;
        logic          ok;
        logic [HO-1:0] gs;
        logic [HO:0]   ge;
    } row_t;

    typedef struct {
        logic          ok;
        logic [HO-1:0] gs;
        logic [HO:0]   ge;
    } grant_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          func = ba_pkg::FUNC_ALLOC;
    logic [HO:0]   req_size = '0;
    logic [HO-1:0] free_start = '0;
    logic [HO:0]   free_end = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic          ok;
    logic [HO-1:0] got_start;
    logic [HO:0]   got_end;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [HO:0]   cfg_data = '0;

    buddy_allocator_top #(.HEAP_ORDER(HO)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .req_size   (req_size),
        .free_start (free_start),
        .free_end   (free_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ok         (ok),
        .got_start  (got_start),
        .got_end    (got_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [HO-1:0] free_q [NORD][$];
    int            max_req;
    grant_t        grant_q [$];
    int            held_s [$];
    int            held_e [$];
    int            send_idle;
    int            recv_idle;
    int            fails;
    int            cycles;

    function automatic bit order_full(int k);
        return free_q[k].size() >= (1 << (HO - k));
    endfunction

    function automatic void stack_push(int k, int pos);
        if (!order_full(k))
            free_q[k].insert(free_q[k].size(), pos[HO-1:0]);
    endfunction

    function automatic bit stack_take(int k, int pos);
        logic [HO-1:0] kept [$];
        int n;
        n = free_q[k].size();
        for (int i = 0; i < n; i++)
            if (free_q[k][i] != pos[HO-1:0])
                kept.insert(kept.size(), free_q[k][i]);
        free_q[k] = kept;
        return kept.size() != n;
    endfunction

    function automatic int log2_floor(int v);
        int r;
        r = 0;
        while (v > 1)
        begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic grant_t predict_grant(logic f, int req, int fs, int fe);
        grant_t g;
        int k, j, pos, bud;
        g = '{1'b0, '0, '0};
        if (f == ba_pkg::FUNC_ALLOC)
        begin
            if (req != 0 && req <= max_req)
            begin
                k = (req == 1) ? 0 : log2_floor(req - 1) + 1;
                if (k <= HO)
                begin
                    j = k;
                    while (j <= HO && free_q[j].size() == 0)
                        j++;
                    if (j <= HO)
                    begin
                        pos = free_q[j][$];
                        free_q[j].delete(free_q[j].size() - 1);
                        while (j > k)
                        begin
                            j--;
                            stack_push(j, pos + (1 << j));
                        end
                        g.ok = 1'b1;
                        g.gs = pos[HO-1:0];
                        g.ge = pos + (1 << k);
                        held_s.insert(held_s.size(), pos);
                        held_e.insert(held_e.size(), pos + (1 << k));
                    end
                end
            end
        end
        else if (fe > fs && fs < UNITS)
        begin
            k = log2_floor(fe - fs);
            pos = fs;
            g.ok = 1'b1;
            foreach (held_s[i])
                if (held_s[i] == fs && held_e[i] == fe)
                begin
                    held_s.delete(i);
                    held_e.delete(i);
                    break;
                end
            forever
            begin
                if (k >= HO)
                begin
                    stack_push(HO, pos);
                    break;
                end
                bud = pos ^ (1 << k);
                if (stack_take(k, bud))
                begin
                    if (bud < pos)
                        pos = bud;
                    k++;
                end
                else
                begin
                    stack_push(k, pos);
                    break;
                end
            end
        end
        return g;
    endfunction

    task automatic send_item(logic f, int req, int fs, int fe, bit typed, grant_t want);
        grant_t g;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        req_size   <= req[HO:0];
        free_start <= fs[HO-1:0];
        free_end   <= fe[HO:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        g = predict_grant(f, req, fs, fe);
        grant_q.insert(grant_q.size(), typed ? want : g);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_max(int v);
        cfg_valid <= 1'b1;
        cfg_data  <= v[HO:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        max_req = v;
    endtask

    task automatic random_item();
        int r, sz, i, fs;
        r = $urandom_range(99);
        if (held_s.size() != 0 && (r < 40 || (held_s.size() > 40 && r < 75)))
        begin
            i = $urandom_range(held_s.size() - 1);
            send_item(ba_pkg::FUNC_FREE, $urandom_range(8191), held_s[i], held_e[i], 0,
                '{0, 0, 0});
        end
        else if (r < 48)
        begin
            fs = $urandom_range(UNITS - 1);
            send_item(ba_pkg::FUNC_FREE, $urandom_range(8191), fs, $urandom_range(fs),
                0, '{0, 0, 0});
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 70)
                sz = $urandom_range(16, 1);
            else if (r < 90)
                sz = $urandom_range(512, 17);
            else if (r < 95)
                sz = $urandom_range(UNITS, 513);
            else if (r < 97)
                sz = 0;
            else
                sz = $urandom_range(8191, (max_req + 1 > 8191) ? 8191 : max_req + 1);
            send_item(ba_pkg::FUNC_ALLOC, sz, $urandom_range(UNITS - 1),
                $urandom_range(8191), 0, '{0, 0, 0});
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        grant_t w;
        out_stall <= ($urandom_range(99) < recv_idle);
        if (rst_n && out_valid && !out_stall)
        begin
            if (grant_q.size() == 0)
            begin
                $error("result with no item outstanding");
                fails++;
            end
            else
            begin
                w = grant_q.pop_front();
                if (ok !== w.ok)
                begin
                    $error("ok: expected %0d, got %0d", w.ok, ok);
                    fails++;
                end
                if (got_start !== w.gs)
                begin
                    $error("got_start: expected %0d, got %0d", w.gs, got_start);
                    fails++;
                end
                if (got_end !== w.ge)
                begin
                    $error("got_end: expected %0d, got %0d", w.ge, got_end);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    row_t dir_rows [23] = '{
        '{ba_pkg::FUNC_ALLOC, 4096, 0,    0,    1, 1, 0, 4096},
        '{ba_pkg::FUNC_FREE,  0,    0,    4096, 1, 1, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 0,    0,    0,    1, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 4097, 0,    0,    1, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 8191, 4095, 8191, 1, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 1,    0,    0,    1, 1, 0, 1},
        '{ba_pkg::FUNC_ALLOC, 1,    0,    0,    0, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 2,    0,    0,    0, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 3,    0,    0,    0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    5,    5,    1, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    4095, 0,    1, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    0,    1,    0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    1,    2,    0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    2,    4,    0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    4,    8,    0, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 4096, 0,    0,    1, 1, 0, 4096},
        '{ba_pkg::FUNC_ALLOC, 1,    0,    0,    1, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    0,    4096, 1, 1, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 2048, 0,    0,    0, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 2049, 0,    0,    1, 0, 0, 0},
        '{ba_pkg::FUNC_ALLOC, 2048, 0,    0,    0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    0,    2048, 0, 0, 0, 0},
        '{ba_pkg::FUNC_FREE,  0,    2048, 4096, 0, 0, 0, 0}
    };

    int phase_max [4];

    initial
    begin
        fails = 0;
        cycles = 0;
        send_idle = 0;
        recv_idle = 0;
        max_req = 4096;
        for (int k = 0; k < NORD; k++)
            free_q[k].delete();
        free_q[HO].insert(0, '0);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].f, dir_rows[i].req, dir_rows[i].fs, dir_rows[i].fe,
                dir_rows[i].typed, '{dir_rows[i].ok, dir_rows[i].gs, dir_rows[i].ge});
        drain();

        phase_max = '{4096, 1, $urandom_range(4096, 1), $urandom_range(600, 8)};
        for (int p = 0; p < 4; p++)
        begin
            write_max(phase_max[p]);
            case (p)
                0: begin send_idle = 0;  recv_idle = 0;  end
                1: begin send_idle = 47; recv_idle = 0;  end
                2: begin send_idle = 0;  recv_idle = 47; end
                default: begin send_idle = 13; recv_idle = 13; end
            endcase
            repeat (N_RAND) random_item();
            drain();
        end

        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
